// ===== hw/rtl/frequency_to_block_fnum_assert.svh =====
// ----------------------------------------------------------------------------
// frequency_to_block_fnum_assert.svh
// Assertion macros used by the converter top level.
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_TO_BLOCK_FNUM_ASSERT_SVH
`define FREQUENCY_TO_BLOCK_FNUM_ASSERT_SVH

// same-cycle implication, held off during reset
`define FTBF_ASSERT_IMPL(lbl, clk_i, rst_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define FTBF_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ftbf_pkg.sv =====
// ----------------------------------------------------------------------------
// ftbf_pkg
// Widths, block range table and divider constants for the converter.
// ----------------------------------------------------------------------------
package ftbf_pkg;

  localparam int FREQ_W = 26;
  localparam int BLK_W  = 3;
  localparam int FNUM_W = 10;
  localparam int NUM_BLK = 8;

  // scaled dividend after the per-block shift; an in-range value fits 22 bits
  localparam int X_W   = 22;
  localparam int D_W   = 13;
  localparam int RCP_W = 25;
  localparam int RCP_S = 32;
  localparam int MUL_W = X_W + RCP_W;
  localparam int Q_W   = FNUM_W + 1;
  localparam int QD_W  = Q_W + D_W;
  localparam int R_W   = 13;

  localparam logic [FREQ_W-1:0] FREQ_MIN = 26'd474;
  localparam logic [FNUM_W-1:0] FNUM_MAX = 10'd1023;

  localparam logic [FREQ_W-1:0] BLK_HI [NUM_BLK] = '{
    26'd485033,  26'd970067,   26'd1940134,  26'd3880269,
    26'd7760538, 26'd15521077, 26'd31042155, 26'd62084311
  };

  // block divisors are BASE_A << shift (blocks 0..2) or BASE_B << shift (3..7)
  localparam logic [2:0] BLK_SHIFT [NUM_BLK] = '{
    3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4
  };
  localparam logic [BLK_W-1:0] FIRST_B_BLK = 3'd3;

  localparam logic [D_W-1:0] BASE_A = 13'd237;
  localparam logic [D_W-1:0] BASE_B = 13'd3793;

  // floor(2^32 / d); estimate is low by at most one for a 22-bit dividend
  localparam logic [RCP_W-1:0] RECIP_A = RCP_W'((64'd1 << RCP_S) / 64'd237);
  localparam logic [RCP_W-1:0] RECIP_B = RCP_W'((64'd1 << RCP_S) / 64'd3793);

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    logic             inr;
    logic             sel_b;
    logic [X_W-1:0]   x;
  } class_t;

endpackage

// ===== hw/rtl/ftbf_classify.sv =====
// ----------------------------------------------------------------------------
// ftbf_classify
// Range compare, block pick and dividend scaling for one frequency.
// ----------------------------------------------------------------------------
module ftbf_classify (
  input  logic [ftbf_pkg::FREQ_W-1:0] frequency,
  output ftbf_pkg::class_t            cls
);
  import ftbf_pkg::*;

  logic [BLK_W-1:0]  blk;
  logic [FREQ_W-1:0] shifted;

  // lowest block whose ceiling is not below the input
  always_comb begin
    blk = '0;
    for (int b = NUM_BLK - 1; b >= 0; b--) begin
      if (frequency <= BLK_HI[b]) begin
        blk = BLK_W'(b);
      end
    end
  end

  assign shifted   = frequency >> BLK_SHIFT[blk];
  assign cls.blk   = blk;
  assign cls.inr   = (frequency >= FREQ_MIN) && (frequency <= BLK_HI[NUM_BLK-1]);
  assign cls.sel_b = (blk >= FIRST_B_BLK);
  assign cls.x     = shifted[X_W-1:0];

endmodule

// ===== hw/rtl/frequency_to_block_fnum.sv =====
// ----------------------------------------------------------------------------
// frequency_to_block_fnum
// Frequency (mHz) to octave block and frequency number, four-stage pipeline.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall  frequency
//  out       output     out_valid / out_stall octave_block, frequency_number,
//                                            in_range
//
//  A transfer in moves through the stage 1, 2, 3 and output registers in turn.
//  One transfer per cycle sustained while out is not stalled; stages are
//  classify, reciprocal multiply, remainder multiply, correct and saturate.
//  Each stage holds while the one below it is full and cannot move, so a
//  stall on out reaches in_stall only once all four stages are occupied.
//  Synchronous reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
`include "frequency_to_block_fnum_assert.svh"

module frequency_to_block_fnum (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ftbf_pkg::FREQ_W-1:0]  frequency,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ftbf_pkg::BLK_W-1:0]   octave_block,
  output logic [ftbf_pkg::FNUM_W-1:0]  frequency_number,
  output logic                         in_range
);
  import ftbf_pkg::*;

  class_t cls;

  logic rdy1, rdy2, rdy3, rdy4;
  logic v1, v2, v3;

  // stage 1
  class_t s1;
  // stage 2
  logic [MUL_W-1:0] s2_prod;
  logic [X_W-1:0]   s2_x;
  logic [BLK_W-1:0] s2_blk;
  logic             s2_inr;
  logic             s2_sel_b;
  // stage 3
  logic [Q_W-1:0]   s3_q0;
  logic [R_W-1:0]   s3_rem;
  logic [BLK_W-1:0] s3_blk;
  logic             s3_inr;
  logic             s3_sel_b;

  logic [RCP_W-1:0] s1_recip;
  logic [Q_W-1:0]   s2_q0;
  logic [D_W-1:0]   s2_d;
  logic [QD_W-1:0]  s2_qd;
  logic [QD_W-1:0]  s2_diff;
  logic [D_W-1:0]   s3_d;
  logic [Q_W-1:0]   s3_q;
  logic [FNUM_W-1:0] s3_fnum;

  ftbf_classify u_classify (
    .frequency (frequency),
    .cls       (cls)
  );

  assign rdy4     = !out_valid || !out_stall;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) out_valid <= v3;
    end
  end

  assign s1_recip = s1.sel_b ? RECIP_B : RECIP_A;

  assign s2_q0   = s2_prod[RCP_S +: Q_W];
  assign s2_d    = s2_sel_b ? BASE_B : BASE_A;
  assign s2_qd   = QD_W'(s2_q0) * QD_W'(s2_d);
  assign s2_diff = QD_W'(s2_x) - s2_qd;

  // reciprocal estimate is at most one short
  assign s3_d    = s3_sel_b ? BASE_B : BASE_A;
  assign s3_q    = s3_q0 + Q_W'(s3_rem >= s3_d);
  assign s3_fnum = (s3_q > Q_W'(FNUM_MAX)) ? FNUM_MAX : s3_q[FNUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1 <= cls;
    end
    if (rdy2) begin
      s2_prod  <= MUL_W'(s1.x) * MUL_W'(s1_recip);
      s2_x     <= s1.x;
      s2_blk   <= s1.blk;
      s2_inr   <= s1.inr;
      s2_sel_b <= s1.sel_b;
    end
    if (rdy3) begin
      s3_q0    <= s2_q0;
      s3_rem   <= s2_diff[R_W-1:0];
      s3_blk   <= s2_blk;
      s3_inr   <= s2_inr;
      s3_sel_b <= s2_sel_b;
    end
    if (rdy4) begin
      octave_block     <= s3_inr ? s3_blk : '0;
      frequency_number <= s3_inr ? s3_fnum : '0;
      in_range         <= s3_inr;
    end
  end

  `FTBF_ASSERT_NEXT(a_enter, clk, rst, in_valid && !in_stall, v1, "transfer in not captured")
  `FTBF_ASSERT_IMPL(a_backpr, clk, rst, in_stall, v1 && v2 && v3 && out_valid && out_stall, "stall with a free stage")
  `FTBF_ASSERT_IMPL(a_rem, clk, rst, v3 && s3_inr, {1'b0, s3_rem} < {s3_d, 1'b0}, "remainder beyond one correction")
  `FTBF_ASSERT_IMPL(a_zero, clk, rst, out_valid && !in_range, octave_block == '0 && frequency_number == '0, "out of range result not zero")

endmodule
